FILE: rtl/multiprecision_byte_multiplier_assert.svh
// assertion macros for the multiprecision byte multiplier
`ifndef MULTIPRECISION_BYTE_MULTIPLIER_ASSERT_SVH
`define MULTIPRECISION_BYTE_MULTIPLIER_ASSERT_SVH

// property must hold in the cycle after the condition
`define MBM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

// property must hold whenever the condition holds
`define MBM_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

FILE: rtl/mbm_pkg.sv
`timescale 1ns / 1ps
package mbm_pkg;
	localparam int MaxBytes = 32;
	localparam int ResBytes = 64;
	localparam int IdxW = $clog2(MaxBytes);
	localparam int RidxW = $clog2(ResBytes);
	localparam int LenW = IdxW + 1;
	localparam int RlenW = RidxW + 1;

	localparam logic [1:0] FUNC_WR_X = 2'd0;
	localparam logic [1:0] FUNC_WR_Y = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;

	localparam logic [1:0] REG_X_LEN = 2'd0;
	localparam logic [1:0] REG_Y_LEN = 2'd1;
	localparam logic [1:0] REG_R_LEN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// controls passed to every accumulator cell
	typedef struct packed {
		logic clear;
		logic add;
		logic shift;
		logic [RidxW-1:0] base;
	} cell_ctl_t;
endpackage

FILE: rtl/multiprecision_byte_multiplier.sv
`timescale 1ns / 1ps
// a multiply runs a clear step, the byte-pair steps on one 8x8 multiplier (none when an
// operand length is zero), a carry drain, then emits lr output bytes, and returns to idle
// after the last byte
// results stream one byte per cycle while m_tready is high, from a chain of 64 accumulator cells
// asynchronous active-low reset; lengths reset to 1, 1 and 2, accumulator to zero
// operand stores are undefined until written
module multiprecision_byte_multiplier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // func
	input  logic [15:0] s_tdata,   // byte_index[4:0], operand_byte[12:5], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // product_byte[7:0], product_index[13:8], zero fill
	output logic        m_tlast,
	output logic        m_tuser,   // space_short
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	`include "multiprecision_byte_multiplier_assert.svh"

	localparam int NCell = mbm_pkg::ResBytes;
	localparam int RidxW = mbm_pkg::RidxW;
	localparam int LenW = mbm_pkg::LenW;
	localparam int RlenW = mbm_pkg::RlenW;

	logic [5:0] x_len_q, y_len_q;
	logic [6:0] r_len_q;
	logic [7:0] x_mem_q [mbm_pkg::MaxBytes];
	logic [7:0] y_mem_q [mbm_pkg::MaxBytes];

	mbm_pkg::state_t state_q, state_d;
	logic [LenW-1:0] lx_q, ly_q;
	logic [RlenW-1:0] lr_q;
	logic [LenW-1:0] i_q, j_q;
	logic [RlenW-1:0] k_q;
	logic short_q;
	logic [7:0] xb_s1, yb_s1;
	logic v_s1;
	logic [RidxW:0] pos_s1;
	logic [15:0] prod_s2;
	logic v_s2;
	logic [RidxW-1:0] pos_s2;

	logic [7:0] cell_val [NCell];
	logic [1:0] cell_carry [NCell];
	mbm_pkg::cell_ctl_t ctl;

	logic [4:0] in_idx;
	logic [7:0] in_byte;
	logic accept, emit_go, pair_last, out_fire;

	assign in_idx = s_tdata[4:0];
	assign in_byte = s_tdata[12:5];
	assign accept = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign cfg_ready = (state_q == mbm_pkg::ST_IDLE);
	assign s_tready = (state_q == mbm_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_len_q <= 6'd1;
			y_len_q <= 6'd1;
			r_len_q <= 7'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mbm_pkg::REG_X_LEN: x_len_q <= cfg_data[5:0];
				mbm_pkg::REG_Y_LEN: y_len_q <= cfg_data[5:0];
				mbm_pkg::REG_R_LEN: r_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser == mbm_pkg::FUNC_WR_X) x_mem_q[in_idx] <= in_byte;
		if (accept && s_tuser == mbm_pkg::FUNC_WR_Y) y_mem_q[in_idx] <= in_byte;
	end

	assign pair_last = (i_q == lx_q - 1'b1) && (j_q == ly_q - 1'b1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mbm_pkg::ST_IDLE:
				if (accept && s_tuser == mbm_pkg::FUNC_MUL) state_d = mbm_pkg::ST_CLEAR;
			mbm_pkg::ST_CLEAR:
				state_d = (lx_q == '0 || ly_q == '0) ? mbm_pkg::ST_DRAIN : mbm_pkg::ST_MAC;
			mbm_pkg::ST_MAC:
				if (pair_last) state_d = mbm_pkg::ST_DRAIN;
			mbm_pkg::ST_DRAIN:
				if (k_q == RlenW'(NCell + 3)) begin
					state_d = (lr_q == '0) ? mbm_pkg::ST_IDLE : mbm_pkg::ST_EMIT;
				end
			mbm_pkg::ST_EMIT:
				if (out_fire && k_q == lr_q - 1'b1) state_d = mbm_pkg::ST_IDLE;
			default: state_d = mbm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.clear = (state_q == mbm_pkg::ST_CLEAR);
		ctl.add = v_s2;
		ctl.base = pos_s2;
		ctl.shift = (state_q == mbm_pkg::ST_EMIT) && out_fire;
		emit_go = (state_q == mbm_pkg::ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbm_pkg::ST_IDLE;
			lx_q <= '0; ly_q <= '0; lr_q <= '0;
			i_q <= '0; j_q <= '0; k_q <= '0;
			short_q <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= (state_q == mbm_pkg::ST_MAC);
			v_s2 <= v_s1 && !pos_s1[RidxW];
			case (state_q)
				mbm_pkg::ST_IDLE: begin
					lx_q <= (x_len_q > 6'd32) ? LenW'(32) : x_len_q;
					ly_q <= (y_len_q > 6'd32) ? LenW'(32) : y_len_q;
					lr_q <= (r_len_q > 7'd64) ? RlenW'(64) : r_len_q;
					i_q <= '0; j_q <= '0; k_q <= '0;
				end
				mbm_pkg::ST_CLEAR:
					short_q <= ({1'b0, lx_q} + {1'b0, ly_q}) > RlenW'(lr_q);
				mbm_pkg::ST_MAC:
					if (j_q == ly_q - 1'b1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				mbm_pkg::ST_DRAIN:
					k_q <= (k_q == RlenW'(NCell + 3)) ? '0 : k_q + 1'b1;
				mbm_pkg::ST_EMIT:
					if (out_fire) k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		xb_s1 <= x_mem_q[i_q[mbm_pkg::IdxW-1:0]];
		yb_s1 <= y_mem_q[j_q[mbm_pkg::IdxW-1:0]];
		pos_s1 <= (RidxW+1)'(i_q) + (RidxW+1)'(j_q);
		prod_s2 <= xb_s1 * yb_s1;
		pos_s2 <= pos_s1[RidxW-1:0];
	end

	// the chain drops bytes at and above lr at emit time, and its top carry leaves
	genvar g;
	generate
		for (g = 0; g < NCell; g++) begin : g_cell
			mbm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.pos      (RidxW'(g)),
				.prod     (prod_s2),
				.carry_in ((g == 0) ? 2'b00 : cell_carry[(g == 0) ? 0 : g-1]),
				.shift_in ((g == NCell-1) ? 8'd0 : cell_val[(g == NCell-1) ? g : g+1]),
				.carry_out(cell_carry[g]),
				.value    (cell_val[g])
			);
		end
	endgenerate

	assign m_tvalid = emit_go;
	assign m_tdata = {2'b00, k_q[RidxW-1:0], cell_val[0]};
	assign m_tlast = (k_q == lr_q - 1'b1);
	assign m_tuser = short_q;

	`MBM_ASSERT_NOW(a_no_accept_busy, clk, arst_n, state_q != mbm_pkg::ST_IDLE, !s_tready, "input taken while busy")
	`MBM_ASSERT_NOW(a_emit_in_range, clk, arst_n, m_tvalid, k_q < lr_q, "emit index past result length")
	`MBM_ASSERT_NEXT(a_last_ends, clk, arst_n, m_tvalid && m_tready && m_tlast, state_q == mbm_pkg::ST_IDLE, "no return to idle after last")
	`MBM_ASSERT_NOW(a_mac_nonempty, clk, arst_n, state_q == mbm_pkg::ST_MAC, lx_q != '0 && ly_q != '0, "multiply loop with empty operand")
endmodule

FILE: rtl/mbm_cell.sv
`timescale 1ns / 1ps
// one product byte of the accumulator chain; adds a product byte when addressed,
// keeps a carry, and hands its carry up to the next cell each cycle
module mbm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mbm_pkg::cell_ctl_t            ctl,
	input  logic [mbm_pkg::RidxW-1:0]     pos,
	input  logic [15:0]                   prod,
	input  logic [1:0]                    carry_in,
	input  logic [7:0]                    shift_in,
	output logic [1:0]                    carry_out,
	output logic [7:0]                    value
);
	logic [7:0] acc_q;
	logic [1:0] carry_q;
	logic [7:0] addend;
	logic [9:0] sum;
	logic [mbm_pkg::RidxW-1:0] rel;

	always_comb begin
		rel = pos - ctl.base;
		addend = 8'd0;
		if (ctl.add && rel == '0) begin
			addend = prod[7:0];
		end else if (ctl.add && rel == {{(mbm_pkg::RidxW-1){1'b0}}, 1'b1}) begin
			addend = prod[15:8];
		end
		sum = {2'b00, acc_q} + {2'b00, addend} + {8'd0, carry_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			carry_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
			carry_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= shift_in;
			carry_q <= '0;
		end else begin
			acc_q <= sum[7:0];
			carry_q <= sum[9:8];
		end
	end

	assign carry_out = carry_q;
	assign value = acc_q;
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
	typedef struct packed {
		logic [7:0] pbyte;
		logic [5:0] pidx;
		logic       plast;
		logic       pshort;
	} prod_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	multiprecision_byte_multiplier u_dut (.*);

	always #5 clk = ~clk;

	logic [5:0] x_len_q, y_len_q;
	logic [6:0] r_len_q;
	logic [7:0] x_mem [mbm_pkg::MaxBytes];
	logic [7:0] y_mem [mbm_pkg::MaxBytes];
	prod_t product_q [$];
	int errors = 0;
	int products_seen = 0;
	int multiplies = 0;
	bit quiet = 1'b0;

	task automatic report(input string what);
		errors++;
		$display("error at %0t: %s", $time, what);
	endtask

	task automatic predict_product();
		int lx, ly, lr, k;
		logic [7:0] acc [mbm_pkg::ResBytes];
		logic [15:0] sum;
		prod_t p;
		lx = (x_len_q > mbm_pkg::MaxBytes) ? mbm_pkg::MaxBytes : x_len_q;
		ly = (y_len_q > mbm_pkg::MaxBytes) ? mbm_pkg::MaxBytes : y_len_q;
		lr = (r_len_q > mbm_pkg::ResBytes) ? mbm_pkg::ResBytes : r_len_q;
		for (int k2 = 0; k2 < mbm_pkg::ResBytes; k2++) acc[k2] = '0;
		for (int i = 0; i < lx; i++)
			for (int j = 0; j < ly; j++) begin
				sum = x_mem[i] * y_mem[j];
				k = i + j;
				while (sum != 0 && k < lr) begin
					sum = sum + acc[k];
					acc[k] = sum[7:0];
					sum = sum >> 8;
					k++;
				end
			end
		for (k = 0; k < lr; k++) begin
			p.pbyte = acc[k];
			p.pidx = k[5:0];
			p.plast = (k + 1 == lr);
			p.pshort = (lx + ly > lr);
			product_q.push_back(p);
		end
		multiplies++;
	endtask

	task automatic send_request(input logic [1:0] func, input logic [4:0] idx,
			input logic [7:0] val);
		while (!quiet && $urandom_range(99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {3'b000, val, idx};
		do @(posedge clk); while (!s_tready);
		case (func)
			mbm_pkg::FUNC_WR_X: x_mem[idx] = val;
			mbm_pkg::FUNC_WR_Y: y_mem[idx] = val;
			mbm_pkg::FUNC_MUL: predict_product();
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (product_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			mbm_pkg::REG_X_LEN: x_len_q = val[5:0];
			mbm_pkg::REG_Y_LEN: y_len_q = val[5:0];
			mbm_pkg::REG_R_LEN: r_len_q = val;
			default: ;
		endcase
	endtask

	task automatic set_lengths(input logic [6:0] lx, input logic [6:0] ly,
			input logic [6:0] lr);
		write_reg(mbm_pkg::REG_X_LEN, lx);
		write_reg(mbm_pkg::REG_Y_LEN, ly);
		write_reg(mbm_pkg::REG_R_LEN, lr);
	endtask

	task automatic load_operands(input int nx, input int ny, input int mode);
		logic [7:0] v;
		for (int i = 0; i < nx; i++) begin
			v = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom);
			send_request(mbm_pkg::FUNC_WR_X, i[4:0], v);
		end
		for (int i = 0; i < ny; i++) begin
			v = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom);
			send_request(mbm_pkg::FUNC_WR_Y, i[4:0], v);
		end
	endtask

	task automatic test_reset_lengths();
		load_operands(1, 1, 1);
		send_request(mbm_pkg::FUNC_MUL, 5'd0, 8'd0);
	endtask

	task automatic test_extremes();
		set_lengths(7'd32, 7'd32, 7'd64);
		load_operands(32, 32, 1);
		send_request(mbm_pkg::FUNC_MUL, 5'd31, 8'hFF);
		send_request(2'd3, 5'd7, 8'hA5);
		set_lengths(7'd63, 7'd63, 7'd127);
		send_request(mbm_pkg::FUNC_MUL, 5'd0, 8'd0);
		set_lengths(7'd0, 7'd5, 7'd3);
		send_request(mbm_pkg::FUNC_MUL, 5'd0, 8'd0);
		set_lengths(7'd32, 7'd32, 7'd1);
		send_request(mbm_pkg::FUNC_MUL, 5'd0, 8'd0);
		set_lengths(7'd32, 7'd32, 7'd0);
		send_request(mbm_pkg::FUNC_MUL, 5'd0, 8'd0);
		set_lengths(7'd1, 7'd1, 7'd2);
		send_request(mbm_pkg::FUNC_WR_X, 5'd0, 8'h00);
		send_request(mbm_pkg::FUNC_MUL, 5'd0, 8'd0);
	endtask

	task automatic test_random();
		int nx, ny, nr;
		for (int n = 0; n < 17; n++) begin
			quiet = (n >= 8 && n < 12);
			nx = (n % 6 == 5) ? $urandom_range(32, 20) : $urandom_range(6, 1);
			ny = (n % 6 == 5) ? $urandom_range(32, 20) : $urandom_range(6, 1);
			nr = $urandom_range(nx + ny + 2, 1);
			set_lengths(7'(nx), 7'(ny), 7'(nr));
			load_operands(nx, ny, (n % 7 == 3) ? 1 : 0);
			for (int r = 0; r < 3; r++) begin
				if ($urandom_range(3) == 0)
					send_request(2'd3, 5'($urandom), 8'($urandom));
				send_request(mbm_pkg::FUNC_WR_X, 5'($urandom_range(nx - 1)), 8'($urandom));
				send_request(mbm_pkg::FUNC_WR_Y, 5'($urandom_range(ny - 1)), 8'($urandom));
				send_request(mbm_pkg::FUNC_MUL, 5'($urandom), 8'($urandom));
			end
		end
		quiet = 1'b0;
	endtask

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= 25);
		if (m_tvalid && m_tready) begin
			prod_t e;
			products_seen++;
			if (product_q.size() == 0) report("product byte with none expected");
			else begin
				e = product_q.pop_front();
				if (m_tdata[7:0] !== e.pbyte)
					report($sformatf("byte %0d: got %h want %h", e.pidx, m_tdata[7:0], e.pbyte));
				if (m_tdata[13:8] !== e.pidx)
					report($sformatf("index: got %0d want %0d", m_tdata[13:8], e.pidx));
				if (m_tdata[15:14] !== 2'b00) report("nonzero fill bits");
				if (m_tlast !== e.plast)
					report($sformatf("last on byte %0d: got %b", e.pidx, m_tlast));
				if (m_tuser !== e.pshort)
					report($sformatf("space_short on byte %0d: got %b", e.pidx, m_tuser));
			end
		end
	end

	initial begin
		x_len_q = 6'd1;
		y_len_q = 6'd1;
		r_len_q = 7'd2;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_lengths();
		test_extremes();
		test_random();
		wait_drained();
		if (product_q.size() != 0) report("products left over");
		$display("ran %0d multiplies, checked %0d product bytes", multiplies, products_seen);
		if (errors == 0)
			$display("multiprecision_byte_multiplier: match");
		else
			$display("multiprecision_byte_multiplier: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("multiprecision_byte_multiplier: mismatch");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/mbm_pkg.sv
rtl/mbm_cell.sv
rtl/multiprecision_byte_multiplier.sv
sim/tb.sv
